/* sv/bfx_pkg.sv */
package bfx_pkg;

  // Bytecode opcodes; codes 12 to 15 are no-ops.
  typedef enum logic [3:0] {
    OP_OUT     = 4'd0,
    OP_IN      = 4'd1,
    OP_JFWD    = 4'd2,
    OP_JBACK   = 4'd3,
    OP_CLEAR   = 4'd4,
    OP_ADD     = 4'd5,
    OP_MOVE    = 4'd6,
    OP_ADDNEXT = 4'd7,
    OP_MULMOVE = 4'd8,
    OP_SET     = 4'd9,
    OP_SCANR   = 4'd10,
    OP_SCANL   = 4'd11
  } op_t;

  // Tape write address source.
  typedef enum logic [1:0] {
    WA_PTR = 2'd0,
    WA_Q   = 2'd1,
    WA_CLR = 2'd2
  } wa_t;

  // Tape write data source.
  typedef enum logic [2:0] {
    WD_ZERO = 3'd0,
    WD_INB  = 3'd1,
    WD_LOW8 = 3'd2,
    WD_ADD  = 3'd3,
    WD_ACC  = 3'd4
  } wd_t;

  typedef struct packed {
    logic op_ld;       // capture request fields
    logic rd_en;       // load tape read register
    logic q_ld;        // step the walk pointer, read at its new value
    logic q_from_q;    // step from walk pointer (else from cell pointer)
    logic wr_en;
    wa_t  wa;
    wd_t  wd;
    logic ptr_ld;
    logic ptr_from_q;  // take walk pointer (else move target)
    logic prod_ld;
    logic res_ld;
    logic res_fault;
    logic clr_inc;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic cur_zero;    // tape read register is zero
    logic ptr_end;     // cell pointer at the tape end in walk direction
    logic q_end;       // walk pointer at the tape end in walk direction
    logic move_ok;
    logic clr_last;
    logic res_free;    // result register can take a new result
  } sts_t;

endpackage

/* sv/bf_bytecode_execution_unit.sv */
// Channel   Handshake               Payload
// request   in_valid / in_stall     action, amount, in_byte, instr_index, jump_target
// result    res_valid / res_stall   out_valid, out_byte, next_index, fault
//
// Steps: most opcodes take an accept and an execute step, addnext and mulmove
//   add a second-cell step, and a scan walks cell by cell; the tape read is registered.
// Reset: a clearing pass writes zero to all 2*HALF_CELLS cells, one per cycle,
//   with in_stall high; the pointer starts at HALF_CELLS.
// Stalls: a new request is taken while an earlier result waits; a finished
//   request holds in its last step until the result register frees up.
module bf_bytecode_execution_unit #(
  parameter int HALF_CELLS = 16384
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         action,
  input  logic signed [16:0] amount,
  input  logic [7:0]         in_byte,
  input  logic [15:0]        instr_index,
  input  logic [15:0]        jump_target,
  output logic               res_valid,
  input  logic               res_stall,
  output logic               out_valid,
  output logic [7:0]         out_byte,
  output logic [16:0]        next_index,
  output logic               fault
);
  import bfx_pkg::*;

  cmd_t cmd;  // controller to datapath
  sts_t sts;  // datapath to controller

  // sequencer: clearing pass, accept, execute, second cell, scan walk
  bfx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // tape memory, pointers, multiplier and result register
  bfx_dp #(
    .HALF_CELLS (HALF_CELLS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .action      (action),
    .amount      (amount),
    .in_byte     (in_byte),
    .instr_index (instr_index),
    .jump_target (jump_target),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .next_index  (next_index),
    .fault       (fault)
  );

endmodule

/* sv/bfx_ctrl.sv */
module bfx_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  bfx_pkg::sts_t sts,
  output bfx_pkg::cmd_t cmd
);
  import bfx_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_NEXT  = 5'b01000,
    S_SCAN  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    cmd.op_ld      = 1'b0;
    cmd.rd_en      = 1'b0;
    cmd.q_ld       = 1'b0;
    cmd.q_from_q   = 1'b0;
    cmd.wr_en      = 1'b0;
    cmd.wa         = WA_PTR;
    cmd.wd         = WD_ZERO;
    cmd.ptr_ld     = 1'b0;
    cmd.ptr_from_q = 1'b0;
    cmd.prod_ld    = 1'b0;
    cmd.res_ld     = 1'b0;
    cmd.res_fault  = 1'b0;
    cmd.clr_inc    = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.wr_en   = 1'b1;
        cmd.wa      = WA_CLR;
        cmd.clr_inc = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op_ld  = 1'b1;
          cmd.rd_en  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.res_free) begin
          state_next = S_IDLE;
          unique case (sts.op)
            OP_IN: begin
              cmd.wr_en  = 1'b1;
              cmd.wd     = WD_INB;
              cmd.res_ld = 1'b1;
            end
            OP_CLEAR: begin
              cmd.wr_en  = 1'b1;
              cmd.res_ld = 1'b1;
            end
            OP_ADD: begin
              cmd.wr_en  = 1'b1;
              cmd.wd     = WD_ADD;
              cmd.res_ld = 1'b1;
            end
            OP_SET: begin
              cmd.wr_en  = 1'b1;
              cmd.wd     = WD_LOW8;
              cmd.res_ld = 1'b1;
            end
            OP_MOVE: begin
              cmd.ptr_ld    = sts.move_ok;
              cmd.res_ld    = 1'b1;
              cmd.res_fault = !sts.move_ok;
            end
            OP_ADDNEXT, OP_MULMOVE: begin
              if (sts.ptr_end) begin
                cmd.res_ld    = 1'b1;
                cmd.res_fault = 1'b1;
              end else begin
                cmd.wr_en   = 1'b1;
                cmd.prod_ld = 1'b1;
                cmd.q_ld    = 1'b1;
                cmd.rd_en   = 1'b1;
                state_next  = S_NEXT;
              end
            end
            OP_SCANR, OP_SCANL: begin
              if (sts.cur_zero) begin
                cmd.res_ld = 1'b1;
              end else if (sts.ptr_end) begin
                cmd.res_ld    = 1'b1;
                cmd.res_fault = 1'b1;
              end else begin
                cmd.q_ld   = 1'b1;
                cmd.rd_en  = 1'b1;
                state_next = S_SCAN;
              end
            end
            default: begin
              // out, jumps and no-ops only report
              cmd.res_ld = 1'b1;
            end
          endcase
        end
      end
      S_NEXT: begin
        if (sts.res_free) begin
          cmd.wr_en  = 1'b1;
          cmd.wa     = WA_Q;
          cmd.wd     = WD_ACC;
          cmd.res_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!sts.cur_zero && !sts.q_end) begin
          cmd.q_ld     = 1'b1;
          cmd.q_from_q = 1'b1;
          cmd.rd_en    = 1'b1;
        end else if (sts.res_free) begin
          cmd.ptr_ld     = sts.cur_zero;
          cmd.ptr_from_q = 1'b1;
          cmd.res_ld     = 1'b1;
          cmd.res_fault  = !sts.cur_zero;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  a_scan_op: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> (sts.op == OP_SCANR || sts.op == OP_SCANL))
    else $error("scan state entered for a non-scan opcode");

  a_next_op: assert property (@(posedge clk) disable iff (rst)
    state == S_NEXT |-> (sts.op == OP_ADDNEXT || sts.op == OP_MULMOVE))
    else $error("second-cell state entered for wrong opcode");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == S_EXEC)
    else $error("accepted request did not start execution");

endmodule

/* sv/bfx_dp.sv */
module bfx_dp #(
  parameter int HALF_CELLS = 16384
) (
  input  logic               clk,
  input  logic               rst,
  input  bfx_pkg::cmd_t      cmd,
  output bfx_pkg::sts_t      sts,
  input  logic [3:0]         action,
  input  logic signed [16:0] amount,
  input  logic [7:0]         in_byte,
  input  logic [15:0]        instr_index,
  input  logic [15:0]        jump_target,
  output logic               res_valid,
  input  logic               res_stall,
  output logic               out_valid,
  output logic [7:0]         out_byte,
  output logic [16:0]        next_index,
  output logic               fault
);
  import bfx_pkg::*;

  localparam int TAPE = 2 * HALF_CELLS;
  localparam int PW   = $clog2(TAPE);
  localparam int MW   = ((PW > 17) ? PW : 17) + 1;
  localparam logic [PW-1:0] LAST  = PW'(TAPE - 1);
  localparam logic [PW-1:0] START = PW'(HALF_CELLS);

  logic [7:0]    tape [TAPE];
  logic [7:0]    rdata;
  logic [PW-1:0] ptr, q, clr_cnt;
  op_t           op;
  logic [16:0]   amt;
  logic [7:0]    inb, prod;
  logic [15:0]   idx, tgt;

  logic          left;
  logic [PW-1:0] q_base, q_next, rd_addr, wr_addr;
  logic [7:0]    wr_data;
  logic [7:0]    mul;
  logic          neg;
  logic [16:0]   mag;
  logic [MW-1:0] sum, diff;
  logic          taken, is_out;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.op_ld) begin
      op  <= op_t'(action);
      amt <= amount;
      inb <= in_byte;
      idx <= instr_index;
      tgt <= jump_target;
    end
  end

  assign left   = (op == OP_SCANL);
  assign q_base = cmd.q_from_q ? q : ptr;
  assign q_next = left ? (q_base - PW'(1)) : (q_base + PW'(1));

  assign rd_addr = cmd.q_ld ? q_next : ptr;

  always_comb begin
    unique case (cmd.wa)
      WA_PTR:  wr_addr = ptr;
      WA_Q:    wr_addr = q;
      WA_CLR:  wr_addr = clr_cnt;
      default: wr_addr = ptr;
    endcase
  end

  always_comb begin
    unique case (cmd.wd)
      WD_ZERO: wr_data = 8'd0;
      WD_INB:  wr_data = inb;
      WD_LOW8: wr_data = amt[7:0];
      WD_ADD:  wr_data = rdata + amt[7:0];
      WD_ACC:  wr_data = rdata + prod;
      default: wr_data = 8'd0;
    endcase
  end

  // tape memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) tape[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rdata <= tape[rd_addr];
  end

  // only the low byte of the product matters
  assign mul = rdata * amt[7:0];

  always_ff @(posedge clk) begin
    if (cmd.prod_ld) prod <= (op == OP_MULMOVE) ? mul : rdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.q_ld) q <= q_next;
  end

  // signed move distance as sign and magnitude
  assign neg  = amt[16];
  assign mag  = neg ? (~amt + 17'd1) : amt;
  assign sum  = MW'(ptr) + MW'(mag);
  assign diff = MW'(ptr) - MW'(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr     <= START;
      clr_cnt <= '0;
    end else begin
      if (cmd.ptr_ld) ptr <= cmd.ptr_from_q ? q : (neg ? diff[PW-1:0] : sum[PW-1:0]);
      if (cmd.clr_inc) clr_cnt <= clr_cnt + PW'(1);
    end
  end

  assign sts.op       = op;
  assign sts.cur_zero = (rdata == 8'd0);
  assign sts.ptr_end  = left ? (ptr == '0) : (ptr == LAST);
  assign sts.q_end    = left ? (q == '0) : (q == LAST);
  assign sts.move_ok  = neg ? (MW'(ptr) >= MW'(mag)) : (sum < MW'(TAPE));
  assign sts.clr_last = (clr_cnt == LAST);
  assign sts.res_free = !res_valid || !res_stall;

  assign is_out = (op == OP_OUT);
  assign taken  = ((op == OP_JFWD) && (rdata == 8'd0)) ||
                  ((op == OP_JBACK) && (rdata != 8'd0));

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.res_ld) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      out_valid  <= is_out;
      out_byte   <= is_out ? rdata : 8'd0;
      next_index <= (taken ? {1'b0, tgt} : {1'b0, idx}) + 17'd1;
      fault      <= cmd.res_fault;
    end
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr <= LAST)
    else $error("cell pointer left the tape");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_ld |-> sts.res_free)
    else $error("result loaded over a waiting result");

  a_res_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.res_ld |=> res_valid)
    else $error("loaded result not presented");

endmodule
